/* hw/rtl/vfp_pkg.sv */
// ----------------------------------------------------------------------------
// vfp_pkg: shared types and constants for the voxel file parser
// Phase codes, result kinds, error codes and the request record that moves
// from the byte front end to the palette back end.
// ----------------------------------------------------------------------------
package vfp_pkg;

	localparam int unsigned PaletteEntriesDefault = 4096;
	localparam logic [16:0] MaterialLimit = 17'd65536;
	localparam logic [31:0] VersionWord   = 32'h0101_0000;

	typedef enum logic [3:0] {
		PH_VERSION, PH_HEADER, PH_NAMELEN, PH_NAME, PH_SIZE, PH_POS,
		PH_VOXEL, PH_DONE, PH_FAILED
	} phase_t;

	typedef enum logic [1:0] {
		KIND_INFO  = 2'd0,
		KIND_VOXEL = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	localparam logic [15:0] ErrVersion = 16'd0;
	localparam logic [15:0] ErrTrunc   = 16'd1;
	localparam logic [15:0] ErrVis     = 16'd2;
	localparam logic [15:0] ErrComp    = 16'd3;
	localparam logic [15:0] ErrFull    = 16'd4;

	// Back end operation carried in a request
	typedef enum logic [1:0] {
		OP_PASS,     // result is complete, forward it
		OP_VOXEL,    // palette lookup needed
		OP_RESTART   // clear the palette (new matrix), forward the info result
	} op_t;

	// Palette unit sequencer states
	typedef enum logic [1:0] {B_IDLE, B_SEARCH, B_CHECK, B_DEAD} bstate_t;

	typedef struct packed {
		op_t          op;
		kind_t        kind;
		logic [31:0]  matrix_index;
		logic [31:0]  coord_x;
		logic [31:0]  coord_y;
		logic [31:0]  coord_z;
		logic [31:0]  pos_x;
		logic [31:0]  pos_y;
		logic [31:0]  pos_z;
		logic [15:0]  material;
		logic [31:0]  color;
		logic         last_voxel;  // result is the last of the file
	} req_t;

endpackage

/* hw/rtl/voxel_file_parser_palette.sv */
// Throughput: one byte per cycle except while the request queue is full (palette search busy or output stalled).
// Reset: arst_n clears all control state; the palette needs no clearing.
// ----------------------------------------------------------------------------
// voxel_file_parser_palette: voxel model byte parser with per-matrix palette
// Front end parses bytes, a short queue feeds the palette back end.
// ----------------------------------------------------------------------------
module voxel_file_parser_palette #(
	parameter int unsigned PALETTE_ENTRIES = vfp_pkg::PaletteEntriesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] matrix_index,
	output logic [31:0] coord_x,
	output logic [31:0] coord_y,
	output logic [31:0] coord_z,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [15:0] material,
	output logic        new_material,
	output logic [31:0] color,
	output logic        last_of_file
);

	logic f_valid, f_stall, q_valid, q_stall, fail;
	vfp_pkg::req_t f_rq, q_rq, res;

	vfp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .data_byte, .stream_end,
		.rq_valid(f_valid), .rq_stall(f_stall), .rq(f_rq), .be_fail(fail)
	);

	vfp_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_rq),
		.rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_rq), .flush(fail)
	);

	vfp_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
		.clk, .arst_n, .rq_valid(q_valid), .rq_stall(q_stall), .rq(q_rq),
		.out_valid, .out_stall, .res, .res_new(new_material), .fail
	);

	assign kind         = res.kind;
	assign matrix_index = res.matrix_index;
	assign coord_x      = res.coord_x;
	assign coord_y      = res.coord_y;
	assign coord_z      = res.coord_z;
	assign pos_x        = res.pos_x;
	assign pos_y        = res.pos_y;
	assign pos_z        = res.pos_z;
	assign material     = res.material;
	assign color        = res.color;
	assign last_of_file = res.last_voxel;

endmodule

/* hw/rtl/vfp_front.sv */
// ----------------------------------------------------------------------------
// vfp_front: byte parser
// Walks version, header, matrix headers and voxel bytes; emits requests.
// ----------------------------------------------------------------------------
module vfp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    data_byte,
	input  logic          stream_end,
	output logic          rq_valid,
	input  logic          rq_stall,
	output vfp_pkg::req_t rq,
	input  logic          be_fail   // back end reported palette full
);

	vfp_pkg::phase_t phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [31:0] shift_q;
	logic        swap_q, swap_d, comp_q, comp_d, vis_q, vis_d;
	logic [31:0] left_q, left_d, mat_q, mat_d;
	logic [31:0] size_q [3];
	logic [31:0] pos_q [3];
	logic [31:0] vc_q [3], vc_d [3];
	logic        emit;
	vfp_pkg::req_t r;
	logic [31:0] sh;
	logic        take;
	logic [1:0]  fi;
	logic        wr_size, wr_pos;

	// one request per byte at most; stall while output slot is blocked
	assign in_stall = rq_stall;
	assign take     = in_valid && !rq_stall;
	assign sh       = {shift_q[23:0], data_byte};
	assign fi       = (cnt_q[3:2] == 2'd0) ? 2'd0 : (cnt_q[3:2] == 2'd1) ? 2'd1 : 2'd2;

	// next state and request
	always_comb begin
		phase_d = phase_q; cnt_d = cnt_q; swap_d = swap_q; comp_d = comp_q;
		vis_d = vis_q; left_d = left_q; mat_d = mat_q;
		vc_d = vc_q; emit = 1'b0; wr_size = 1'b0; wr_pos = 1'b0;
		r = '0;
		r.op = vfp_pkg::OP_PASS;
		r.matrix_index = mat_q;
		if (be_fail) begin
			phase_d = vfp_pkg::PH_FAILED;
		end else if (take && phase_q != vfp_pkg::PH_DONE && phase_q != vfp_pkg::PH_FAILED) begin
			if (stream_end) begin
				emit = 1'b1; r.kind = vfp_pkg::KIND_ERROR; r.material = vfp_pkg::ErrTrunc;
				phase_d = vfp_pkg::PH_FAILED;
			end else begin
				unique case (phase_q)
					vfp_pkg::PH_VERSION: begin
						cnt_d = cnt_q + 8'd1;
						if (cnt_q == 8'd3) begin
							cnt_d = '0;
							if (sh != vfp_pkg::VersionWord) begin
								emit = 1'b1; r.kind = vfp_pkg::KIND_ERROR;
								r.material = vfp_pkg::ErrVersion;
								phase_d = vfp_pkg::PH_FAILED;
							end else phase_d = vfp_pkg::PH_HEADER;
						end
					end
					vfp_pkg::PH_HEADER: begin
						cnt_d = cnt_q + 8'd1;
						if (cnt_q == 8'd3) swap_d = sh != '0;
						else if (cnt_q == 8'd11) comp_d = sh != '0;
						else if (cnt_q == 8'd15) vis_d = sh != '0;
						else if (cnt_q == 8'd19) begin
							cnt_d = '0;
							mat_d = '0;
							left_d = sh;
							r.matrix_index = '0;
							if (vis_q) begin
								emit = 1'b1; r.kind = vfp_pkg::KIND_ERROR;
								r.material = vfp_pkg::ErrVis;
								r.matrix_index = mat_q;
								phase_d = vfp_pkg::PH_FAILED;
							end else if (sh == '0) begin
								emit = 1'b1; r.kind = vfp_pkg::KIND_END; r.last_voxel = 1'b1;
								phase_d = vfp_pkg::PH_DONE;
							end else phase_d = vfp_pkg::PH_NAMELEN;
						end
					end
					vfp_pkg::PH_NAMELEN: begin
						cnt_d = data_byte;
						phase_d = (data_byte == 8'd0) ? vfp_pkg::PH_SIZE : vfp_pkg::PH_NAME;
					end
					vfp_pkg::PH_NAME: begin
						cnt_d = cnt_q - 8'd1;
						if (cnt_q == 8'd1) phase_d = vfp_pkg::PH_SIZE;
					end
					vfp_pkg::PH_SIZE: begin
						cnt_d = cnt_q + 8'd1;
						wr_size = cnt_q[1:0] == 2'd3;
						if (cnt_q == 8'd11) begin
							cnt_d = '0; phase_d = vfp_pkg::PH_POS;
						end
					end
					vfp_pkg::PH_POS: begin
						cnt_d = cnt_q + 8'd1;
						wr_pos = cnt_q[1:0] == 2'd3;
						if (cnt_q == 8'd11) begin
							cnt_d = '0;
							emit = 1'b1;
							if (comp_q) begin
								r.kind = vfp_pkg::KIND_ERROR; r.material = vfp_pkg::ErrComp;
								phase_d = vfp_pkg::PH_FAILED;
							end else begin
								r.kind = vfp_pkg::KIND_INFO;
								r.coord_x = size_q[0]; r.coord_y = size_q[1];
								r.coord_z = size_q[2];
								r.pos_x = pos_q[0]; r.pos_y = pos_q[1]; r.pos_z = sh;
								if (size_q[0] == '0 || size_q[1] == '0 || size_q[2] == '0) begin
									left_d = left_q - 32'd1;
									if (left_q == 32'd1) begin
										r.last_voxel = 1'b1; phase_d = vfp_pkg::PH_DONE;
									end else begin
										mat_d = mat_q + 32'd1; phase_d = vfp_pkg::PH_NAMELEN;
									end
								end else begin
									// info result also resets the palette
									r.op = vfp_pkg::OP_RESTART;
									phase_d = vfp_pkg::PH_VOXEL;
									vc_d[0] = '0; vc_d[1] = '0; vc_d[2] = '0;
								end
							end
						end
					end
					vfp_pkg::PH_VOXEL: begin
						cnt_d = cnt_q + 8'd1;
						if (cnt_q == 8'd3) begin
							cnt_d = '0;
							r.kind = vfp_pkg::KIND_VOXEL;
							r.coord_x = vc_q[0]; r.coord_y = vc_q[1]; r.coord_z = vc_q[2];
							r.color = swap_q ? {sh[15:8], sh[23:16], sh[31:24], sh[7:0]}
							                 : sh;
							r.op = vfp_pkg::OP_VOXEL;
							emit = sh[7:0] != 8'd0;
							// coordinate walk, x fastest
							vc_d[0] = vc_q[0] + 32'd1;
							if (vc_d[0] == size_q[0]) begin
								vc_d[0] = '0; vc_d[1] = vc_q[1] + 32'd1;
								if (vc_d[1] == size_q[1]) begin
									vc_d[1] = '0; vc_d[2] = vc_q[2] + 32'd1;
									if (vc_d[2] == size_q[2]) begin
										vc_d[2] = '0;
										left_d = left_q - 32'd1;
										if (left_q == 32'd1) begin
											phase_d = vfp_pkg::PH_DONE;
											r.last_voxel = 1'b1;
											if (!emit) begin
												emit = 1'b1; r.kind = vfp_pkg::KIND_END;
												r.op = vfp_pkg::OP_PASS;
												r.coord_x = '0; r.coord_y = '0;
												r.coord_z = '0; r.color = '0;
											end
										end else begin
											mat_d = mat_q + 32'd1;
											phase_d = vfp_pkg::PH_NAMELEN;
										end
									end
								end
							end
						end
					end
					default: phase_d = vfp_pkg::PH_FAILED;
				endcase
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vfp_pkg::PH_VERSION;
			cnt_q <= '0; shift_q <= '0; swap_q <= 1'b0; comp_q <= 1'b0; vis_q <= 1'b0;
			left_q <= '0; mat_q <= '0;
			for (int i = 0; i < 3; i++) begin
				size_q[i] <= '0; pos_q[i] <= '0; vc_q[i] <= '0;
			end
			rq_valid <= 1'b0;
		end else begin
			phase_q <= phase_d; cnt_q <= cnt_d; swap_q <= swap_d; comp_q <= comp_d;
			vis_q <= vis_d; left_q <= left_d; mat_q <= mat_d;
			vc_q <= vc_d;
			if (take && !stream_end) shift_q <= sh;
			if (wr_size) size_q[fi] <= sh;
			if (wr_pos) pos_q[fi] <= sh;
			if (!rq_stall) rq_valid <= emit;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (!rq_stall) rq <= r;
	end

endmodule

/* hw/rtl/vfp_queue.sv */
// ----------------------------------------------------------------------------
// vfp_queue: two-entry request queue
// Decouples the parser from the palette search.
// ----------------------------------------------------------------------------
module vfp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_stall,
	input  vfp_pkg::req_t wr_data,
	output logic          rd_valid,
	input  logic          rd_stall,
	output vfp_pkg::req_t rd_data,
	input  logic          flush
);

	vfp_pkg::req_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_stall = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall && !flush;
	assign pop      = rd_valid && !rd_stall;

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else if (flush) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

/* hw/rtl/vfp_back.sv */
// ----------------------------------------------------------------------------
// vfp_back: palette unit
// Searches stored colors one at a time, appends new colors, drives results.
// ----------------------------------------------------------------------------
module vfp_back #(
	parameter int unsigned PALETTE_ENTRIES = vfp_pkg::PaletteEntriesDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rq_valid,
	output logic          rq_stall,
	input  vfp_pkg::req_t rq,
	output logic          out_valid,
	input  logic          out_stall,
	output vfp_pkg::req_t res,
	output logic          res_new,
	output logic          fail
);

	localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

	vfp_pkg::bstate_t st_q, st_d;
	logic [31:0] pal_mem [PALETTE_ENTRIES];
	logic [31:0] rdata_q;
	logic [16:0] count_q, count_d;
	logic [16:0] idx_q, idx_d;
	vfp_pkg::req_t cur_q;
	logic        ld, emit, emit_new, wr_en, fail_d;
	vfp_pkg::req_t emit_r;
	logic [16:0] mat;

	assign mat = idx_q + 17'd1;

	// sequencer
	always_comb begin
		st_d = st_q; count_d = count_q; idx_d = idx_q;
		ld = 1'b0; emit = 1'b0; emit_new = 1'b0; wr_en = 1'b0; fail_d = 1'b0;
		emit_r = cur_q;
		rq_stall = 1'b1;
		unique case (st_q)
			vfp_pkg::B_IDLE: begin
				if (!out_valid || !out_stall) begin
					rq_stall = 1'b0;
					if (rq_valid) begin
						unique case (rq.op)
							vfp_pkg::OP_VOXEL: begin
								ld = 1'b1; idx_d = '0; st_d = vfp_pkg::B_SEARCH;
							end
							vfp_pkg::OP_RESTART: begin
								emit = 1'b1; emit_r = rq; count_d = '0;
							end
							default: begin
								emit = 1'b1; emit_r = rq;
								if (rq.kind == vfp_pkg::KIND_ERROR) st_d = vfp_pkg::B_DEAD;
							end
						endcase
					end
				end
			end
			vfp_pkg::B_SEARCH: begin
				// idx_q addresses read issued this cycle
				if (idx_q == count_q) begin
					// not found: append
					if (mat >= vfp_pkg::MaterialLimit || mat > 17'(PALETTE_ENTRIES)) begin
						emit = 1'b1; emit_r = cur_q;
						emit_r.kind = vfp_pkg::KIND_ERROR; emit_r.material = vfp_pkg::ErrFull;
						emit_r.coord_x = '0; emit_r.coord_y = '0; emit_r.coord_z = '0;
						emit_r.color = '0; emit_r.last_voxel = 1'b0;
						fail_d = 1'b1; st_d = vfp_pkg::B_DEAD;
					end else begin
						wr_en = 1'b1; count_d = count_q + 17'd1;
						emit = 1'b1; emit_new = 1'b1; emit_r.material = mat[15:0];
						st_d = vfp_pkg::B_IDLE;
					end
				end else st_d = vfp_pkg::B_CHECK;
			end
			vfp_pkg::B_CHECK: begin
				if (rdata_q == cur_q.color) begin
					emit = 1'b1; emit_r.material = mat[15:0]; st_d = vfp_pkg::B_IDLE;
				end else begin
					idx_d = idx_q + 17'd1; st_d = vfp_pkg::B_SEARCH;
				end
			end
			default: begin
				rq_stall = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= vfp_pkg::B_IDLE; count_q <= '0; idx_q <= '0; out_valid <= 1'b0;
			fail <= 1'b0;
		end else begin
			st_q <= st_d; count_q <= count_d; idx_q <= idx_d; fail <= fail_d;
			if (emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// palette memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) pal_mem[idx_q[AW-1:0]] <= cur_q.color;
		rdata_q <= pal_mem[idx_q[AW-1:0]];
		if (ld) cur_q <= rq;
		if (emit) begin
			res <= emit_r;
			res_new <= emit_new;
		end
	end

endmodule
